[hw/rtl/v3n_pkg.sv]
`default_nettype none
package v3n_pkg;
    localparam int COMP_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int SUM_W    = 2 * COMP_W + 2;        // sum of three squares
    localparam int ROOT_W   = COMP_W + 1;            // root before clamping
    localparam int NUM_W    = 2 * COMP_W - 1;        // |c| << (COMP_W-2)
    localparam int Q_W      = COMP_W - 1;            // quotient <= 2^30
    localparam logic [COMP_W-1:0] MIN_LEN_RST = COMP_W'((64'd1 << FRAC_W) / 64'd10000);

    typedef struct packed {
        logic signed [COMP_W-1:0] vec_x;
        logic signed [COMP_W-1:0] vec_y;
        logic signed [COMP_W-1:0] vec_z;
    } t_vec_in;

    typedef struct packed {
        logic signed [COMP_W-1:0] unit_x;
        logic signed [COMP_W-1:0] unit_y;
        logic signed [COMP_W-1:0] unit_z;
        logic        [COMP_W-1:0] magnitude;
        logic                     too_short;
    } t_vec_out;
endpackage
`default_nettype wire

[hw/rtl/v3n_sqrt_cell.sv]
`default_nettype none
// One restoring square-root step: tries one root bit, sum bits fed two a step
module v3n_sqrt_cell
    import v3n_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [SUM_W-1:0]  i_rad,
    input  wire logic [ROOT_W+1:0] i_rem,
    input  wire logic [ROOT_W-1:0] i_root,
    input  wire logic [COMP_W-1:0] i_mx,
    input  wire logic [COMP_W-1:0] i_my,
    input  wire logic [COMP_W-1:0] i_mz,
    input  wire logic [2:0]        i_neg,
    output logic      [SUM_W-1:0]  o_rad,
    output logic      [ROOT_W+1:0] o_rem,
    output logic      [ROOT_W-1:0] o_root,
    output logic      [COMP_W-1:0] o_mx,
    output logic      [COMP_W-1:0] o_my,
    output logic      [COMP_W-1:0] o_mz,
    output logic      [2:0]        o_neg
);
    logic [ROOT_W+1:0] w_trial, w_test, w_diff;
    logic [SUM_W-1:0]  r_rad;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [COMP_W-1:0] r_mx, r_my, r_mz;
    logic [2:0]        r_neg;

    // bring down two radicand bits, test against 4*root+1
    always_comb begin
        w_trial = {i_rem[ROOT_W-1:0], i_rad[SUM_W-1:SUM_W-2]};
        w_test  = {i_root, 2'b01};
        w_diff  = w_trial - w_test;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad <= {i_rad[SUM_W-3:0], 2'b00};
            r_mx  <= i_mx;
            r_my  <= i_my;
            r_mz  <= i_mz;
            r_neg <= i_neg;
            if (w_trial >= w_test) begin
                r_rem  <= w_diff;
                r_root <= {i_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_trial;
                r_root <= {i_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_mx   = r_mx;
    assign o_my   = r_my;
    assign o_mz   = r_mz;
    assign o_neg  = r_neg;
endmodule
`default_nettype wire

[hw/rtl/v3n_div_cell.sv]
`default_nettype none
// One restoring division step for all three components against the length
module v3n_div_cell
    import v3n_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [COMP_W-1:0] i_den,
    input  wire logic [NUM_W-1:0]  i_num [3],
    input  wire logic [COMP_W:0]   i_rem [3],
    input  wire logic [Q_W-1:0]    i_quo [3],
    input  wire logic [2:0]        i_neg,
    input  wire logic              i_short,
    output logic      [COMP_W-1:0] o_den,
    output logic      [NUM_W-1:0]  o_num [3],
    output logic      [COMP_W:0]   o_rem [3],
    output logic      [Q_W-1:0]    o_quo [3],
    output logic      [2:0]        o_neg,
    output logic                   o_short
);
    logic [COMP_W-1:0] r_den;
    logic [NUM_W-1:0]  r_num [3];
    logic [COMP_W:0]   r_rem [3];
    logic [Q_W-1:0]    r_quo [3];
    logic [2:0]        r_neg;
    logic              r_short;
    logic [COMP_W+1:0] w_sh [3];
    logic [COMP_W+1:0] w_df [3];

    // shift in next numerator bit and try subtracting the divisor
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sh[k] = {i_rem[k], i_num[k][NUM_W-1]};
            w_df[k] = w_sh[k] - {2'b00, i_den};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den   <= i_den;
            r_neg   <= i_neg;
            r_short <= i_short;
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= {i_num[k][NUM_W-2:0], 1'b0};
                if (!w_df[k][COMP_W+1]) begin
                    r_rem[k] <= w_df[k][COMP_W:0];
                    r_quo[k] <= {i_quo[k][Q_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= w_sh[k][COMP_W:0];
                    r_quo[k] <= {i_quo[k][Q_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_den   = r_den;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_neg   = r_neg;
    assign o_short = r_short;
endmodule
`default_nettype wire

[hw/rtl/vector3_normalize.sv]
// vector3_normalize: length and unit vector of a signed Q16.16 3-D vector.
// Input channel i_in_valid / o_in_stall carries one vector item (t_vec_in);
// it is accepted on a rising edge with valid high and stall low.
// Output channel o_out_valid / i_out_stall carries one result item
// (t_vec_out): Q2.30 unit components, Q16.16 magnitude and too_short.
// Configuration: i_cfg_valid / o_cfg_ready writes min_length (ready is
// always high); write it only while the block is idle. Reset value 6.
// The pipeline is a row of cells: 1 squaring stage, 1 sum stage, 33
// square-root cells (one root bit each), 1 compare stage, 63 division cells
// (one quotient bit each, three components side by side) and 1 output stage,
// 100 register stages in all; an accepted item passes through them in order
// and then shows on the output with valid high.
// Throughput is one item per cycle unless the output stalls. The whole
// row advances together when the output register is empty or being taken;
// a stall on the output therefore freezes the pipeline and raises o_in_stall
// whenever the output register holds a waiting item and i_out_stall is high.
// Synchronous active-low reset clears all valid flags and sets min_length
// to its reset value.
`default_nettype none
module vector3_normalize
    import v3n_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_vec_in     i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_vec_out         o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [COMP_W-1:0] i_cfg_data
);
    localparam int NSQ  = ROOT_W;     // root bits (sum fits 2*ROOT_W bits)
    localparam int NDV  = NUM_W;      // quotient steps
    localparam int NSTG = 2 + NSQ + 1 + NDV;

    logic [COMP_W-1:0] r_min_len;
    logic [NSTG-1:0]   r_vld;
    logic              w_adv;
    logic              r_out_vld;
    t_vec_out          r_out;

    // advance when output is free or being drained
    assign w_adv       = !r_out_vld || !i_out_stall;
    assign o_in_stall  = !w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_LEN_RST;
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) r_min_len <= i_cfg_data;
            if (w_adv) begin
                r_vld     <= {r_vld[NSTG-2:0], i_in_valid};
                r_out_vld <= r_vld[NSTG-1];
            end
        end
    end

    // stage 0: magnitudes and squares
    logic [COMP_W-1:0]   r_m0 [3];
    logic [2*COMP_W-1:0] r_sq [3];
    logic [2:0]          r_n0;
    logic [COMP_W-1:0]   w_abs [3];
    always_comb begin
        w_abs[0] = i_in_data.vec_x[COMP_W-1] ? COMP_W'(-i_in_data.vec_x) : i_in_data.vec_x;
        w_abs[1] = i_in_data.vec_y[COMP_W-1] ? COMP_W'(-i_in_data.vec_y) : i_in_data.vec_y;
        w_abs[2] = i_in_data.vec_z[COMP_W-1] ? COMP_W'(-i_in_data.vec_z) : i_in_data.vec_z;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_n0 <= {i_in_data.vec_x[COMP_W-1], i_in_data.vec_y[COMP_W-1],
                     i_in_data.vec_z[COMP_W-1]};
            for (int k = 0; k < 3; k++) begin
                r_m0[k] <= w_abs[k];
                r_sq[k] <= w_abs[k] * w_abs[k];
            end
        end
    end

    // stage 1: sum of squares
    logic [SUM_W-1:0]  r_sum;
    logic [COMP_W-1:0] r_m1 [3];
    logic [2:0]        r_n1;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sum <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
            r_m1  <= r_m0;
            r_n1  <= r_n0;
        end
    end

    // square-root row
    logic [SUM_W-1:0]  s_rad  [NSQ+1];
    logic [ROOT_W+1:0] s_rem  [NSQ+1];
    logic [ROOT_W-1:0] s_root [NSQ+1];
    logic [COMP_W-1:0] s_mx [NSQ+1], s_my [NSQ+1], s_mz [NSQ+1];
    logic [2:0]        s_neg [NSQ+1];
    assign s_rad[0]  = r_sum;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_mx[0]   = r_m1[0];
    assign s_my[0]   = r_m1[1];
    assign s_mz[0]   = r_m1[2];
    assign s_neg[0]  = r_n1;
    for (genvar g = 0; g < NSQ; g++) begin : g_sq
        v3n_sqrt_cell u_cell (
            .i_clk(i_clk), .i_en(w_adv),
            .i_rad(s_rad[g]), .i_rem(s_rem[g]), .i_root(s_root[g]),
            .i_mx(s_mx[g]), .i_my(s_my[g]), .i_mz(s_mz[g]), .i_neg(s_neg[g]),
            .o_rad(s_rad[g+1]), .o_rem(s_rem[g+1]), .o_root(s_root[g+1]),
            .o_mx(s_mx[g+1]), .o_my(s_my[g+1]), .o_mz(s_mz[g+1]),
            .o_neg(s_neg[g+1])
        );
    end

    // compare stage: length against min_length, set up numerators
    logic [COMP_W-1:0] r_len;
    logic              r_short;
    logic [NUM_W-1:0]  r_num [3];
    logic [2:0]        r_n2;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_len   <= s_root[NSQ][COMP_W-1:0];
            r_short <= s_root[NSQ][COMP_W-1:0] <= r_min_len;
            r_num[0] <= NUM_W'({s_mx[NSQ], {(COMP_W-2){1'b0}}});
            r_num[1] <= NUM_W'({s_my[NSQ], {(COMP_W-2){1'b0}}});
            r_num[2] <= NUM_W'({s_mz[NSQ], {(COMP_W-2){1'b0}}});
            r_n2    <= s_neg[NSQ];
        end
    end

    // division row
    logic [COMP_W-1:0] d_den [NDV+1];
    logic [NUM_W-1:0]  d_num [NDV+1][3];
    logic [COMP_W:0]   d_rem [NDV+1][3];
    logic [Q_W-1:0]    d_quo [NDV+1][3];
    logic [2:0]        d_neg [NDV+1];
    logic              d_short [NDV+1];
    assign d_den[0]   = r_len;
    assign d_num[0]   = r_num;
    assign d_neg[0]   = r_n2;
    assign d_short[0] = r_short;
    for (genvar k = 0; k < 3; k++) begin : g_init
        assign d_rem[0][k] = '0;
        assign d_quo[0][k] = '0;
    end
    for (genvar g = 0; g < NDV; g++) begin : g_dv
        v3n_div_cell u_cell (
            .i_clk(i_clk), .i_en(w_adv),
            .i_den(d_den[g]), .i_num(d_num[g]), .i_rem(d_rem[g]),
            .i_quo(d_quo[g]), .i_neg(d_neg[g]), .i_short(d_short[g]),
            .o_den(d_den[g+1]), .o_num(d_num[g+1]), .o_rem(d_rem[g+1]),
            .o_quo(d_quo[g+1]), .o_neg(d_neg[g+1]), .o_short(d_short[g+1])
        );
    end

    // output register: sign, zeroing
    logic [COMP_W-1:0] w_u [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_u[k] = {1'b0, d_quo[NDV][k]};
            if (d_neg[NDV][2-k]) w_u[k] = -w_u[k];
            if (d_short[NDV]) w_u[k] = '0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.unit_x    <= w_u[0];
            r_out.unit_y    <= w_u[1];
            r_out.unit_z    <= w_u[2];
            r_out.magnitude <= d_den[NDV];
            r_out.too_short <= d_short[NDV];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire
